>>> hdl/rpl_pkg.sv
// shared types, widths and constants of the rms peak led meter
package rpl_pkg;

  localparam int unsigned MaxFrame = 4096;
  localparam int unsigned CntW     = $clog2(MaxFrame + 1);

  localparam int unsigned SmpW  = 16;
  localparam int unsigned MagW  = 16;
  localparam int unsigned SqW   = 2 * MagW;
  localparam int unsigned SumW  = 2 * MagW - 2 + CntW;
  localparam int unsigned MeanW = 32;
  localparam int unsigned RmsW  = 16;
  localparam int unsigned LedW  = 8;
  localparam int unsigned DecW  = 16;
  localparam int unsigned PctW  = 7;
  localparam int unsigned PrdW  = RmsW + PctW;
  localparam int unsigned GprW  = PctW + LedW;

  // shared divider: dividend as wide as the square sum, divisor as wide as the peak
  localparam int unsigned DivW    = SumW;
  localparam int unsigned DvsW    = 16;
  localparam int unsigned DivCntW = $clog2(DivW);

  // floor(x / 100) as (x * 5243) >> 19, exact for any x below 2^15
  localparam int unsigned RecipW   = 13;
  localparam int unsigned RecipSh  = 19;
  localparam logic [RecipW-1:0] Recip100 = 13'd5243;

  localparam int unsigned CfgDataW = 16;

  localparam logic [LedW-1:0] LedMaxRst  = 8'd24;
  localparam logic [DecW-1:0] DecayRst   = 16'd328;
  localparam logic [PctW-1:0] Hundred    = 7'd100;

  typedef enum logic [0:0] {
    CFG_LED_MAX = 1'b0,
    CFG_DECAY   = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ADD,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_CMP,
    ST_PCT_GO,
    ST_PCT_WAIT,
    ST_GRN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

>>> hdl/rpl_if.sv
// valid/ready channel interfaces for sample input and led result output
interface rpl_in_if;
  import rpl_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [SmpW-1:0] sample;
  logic                   last_of_frame;

  modport source (output valid, output sample, output last_of_frame, input ready);
  modport sink   (input valid, input sample, input last_of_frame, output ready);
endinterface

interface rpl_out_if;
  import rpl_pkg::*;

  logic            valid;
  logic            ready;
  logic [LedW-1:0] red_level;
  logic [LedW-1:0] green_level;
  logic [LedW-1:0] blue_level;
  logic [RmsW-1:0] rms_value;

  modport source (output valid, output red_level, output green_level, output blue_level,
                  output rms_value, input ready);
  modport sink   (input valid, input red_level, input green_level, input blue_level,
                  input rms_value, output ready);
endinterface

>>> hdl/rpl_div.sv
// shared restoring divider, one quotient bit per cycle
module rpl_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rpl_pkg::DivW-1:0]     dividend_i,
  input  logic [rpl_pkg::DvsW-1:0]     divisor_i,
  output rpl_pkg::unit_stat_t          stat_o,
  output logic [rpl_pkg::DivW-1:0]     quot_o
);
  import rpl_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0]    quo_q, quo_d;
  logic [DvsW-1:0]    rem_q, rem_d;
  logic [DvsW-1:0]    dvs_q, dvs_d;

  logic [DvsW:0] rem_sh;
  logic [DvsW:0] diff;
  logic          ge;

  assign rem_sh = {rem_q, quo_q[DivW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = ~diff[DvsW];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DivW-2:0], ge};
      rem_d = ge ? diff[DvsW-1:0] : rem_sh[DvsW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

>>> hdl/rpl_isqrt.sv
// iterative integer square root, one result bit per cycle
module rpl_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rpl_pkg::MeanW-1:0] val_i,
  output rpl_pkg::unit_stat_t       stat_o,
  output logic [rpl_pkg::RmsW-1:0]  root_o
);
  import rpl_pkg::*;

  localparam logic [MeanW-1:0] Bit0 = MeanW'(1) << (MeanW - 2);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [MeanW-1:0] v_q, v_d;
  logic [MeanW-1:0] root_q, root_d;
  logic [MeanW-1:0] bit_q, bit_d;
  logic [MeanW-1:0] trial;

  assign trial = root_q + bit_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    v_d    = v_q;
    root_d = root_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      v_d    = val_i;
      root_d = '0;
      bit_d  = Bit0;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_d    = v_q - trial;
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
      // lowest bit pair ends the pass
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q[RmsW-1:0];

endmodule

>>> hdl/rms_peak_led_meter_core.sv
// top level: sample accumulation, frame rms, peak hold with decay and led levels
//
// Each accepted sample word passes three steps: accept, square, accumulate into the
// 43-bit square sum (up to 4096 samples a frame count; later ones are dropped until
// the frame closes). A word marked last_of_frame then runs the frame math through
// one shared bit-serial divider and a bit-serial square root. A frame that sets a
// new peak, or that finds the held peak at zero, ends there; any other frame also
// runs the green share, which needs one more division and a reciprocal multiply
// for the scale by one hundredth. Input ready is low from accept until the block
// is back in idle. Results leave through an output register, so the next sample
// word is taken while a result still waits; a frame only stalls at its end when
// the previous result has not been taken yet. Configuration writes take effect at
// once and belong between frames.
module rms_peak_led_meter_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rpl_in_if.sink                         in_ch,
  rpl_out_if.source                      out_ch,
  input  logic                           cfg_we_i,
  input  rpl_pkg::cfg_idx_e              cfg_idx_i,
  input  logic [rpl_pkg::CfgDataW-1:0]   cfg_data_i
);
  import rpl_pkg::*;

  state_e state_q, state_d;

  logic [SumW-1:0] sum_q;
  logic [CntW-1:0] cnt_q;
  logic [RmsW-1:0] peak_q;
  logic            tog_q;
  logic [LedW-1:0] led_max_q;
  logic [DecW-1:0] decay_q;

  logic [MagW-1:0] mag_q;
  logic            last_q;
  logic [SqW-1:0]  sq_q;
  logic [RmsW-1:0] rms_q;
  logic [PrdW-1:0] prod_q;
  logic [GprW-1:0] gprod_q;
  logic [LedW-1:0] red_q, green_q, blue_q;

  logic            out_vld_q;
  logic [LedW-1:0] out_red_q, out_green_q, out_blue_q;
  logic [RmsW-1:0] out_rms_q;

  logic             div_start, sqrt_start;
  logic [DivW-1:0]  div_dividend;
  logic [DvsW-1:0]  div_divisor;
  unit_stat_t       div_stat, sqrt_stat;
  logic [DivW-1:0]  div_quot;
  logic [RmsW-1:0]  sqrt_root;
  logic [MeanW-1:0] mean;
  logic [MagW-1:0]  mag;
  logic             out_free;
  logic [RmsW-1:0]  peak_decayed;
  logic [GprW+RecipW-1:0] grn_prod;

  rpl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  rpl_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .val_i   (mean),
    .stat_o  (sqrt_stat),
    .root_o  (sqrt_root)
  );

  assign mag = in_ch.sample[SmpW-1] ? MagW'(~in_ch.sample + 1'b1) : MagW'(in_ch.sample);
  // mean square never passes 2^30, saturation only guards the upper quotient bits
  assign mean = (div_quot[DivW-1:MeanW] != '0) ? '1 : div_quot[MeanW-1:0];
  assign out_free = ~out_vld_q | out_ch.ready;
  assign peak_decayed = (peak_q > decay_q) ? (peak_q - decay_q) : '0;
  assign grn_prod = gprod_q * Recip100;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_ch.valid) state_d = ST_SQUARE;
      ST_SQUARE:    state_d = ST_ADD;
      ST_ADD:       state_d = last_q ? ST_MEAN_GO : ST_IDLE;
      ST_MEAN_GO:   state_d = ST_MEAN_WAIT;
      ST_MEAN_WAIT: if (div_stat.done) state_d = ST_SQRT_GO;
      ST_SQRT_GO:   state_d = ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (sqrt_stat.done) state_d = ST_CMP;
      ST_CMP: begin
        if ((rms_q > peak_q) || (peak_q == '0)) state_d = ST_FIN;
        else state_d = ST_PCT_GO;
      end
      ST_PCT_GO:    state_d = ST_PCT_WAIT;
      ST_PCT_WAIT:  if (div_stat.done) state_d = ST_GRN;
      ST_GRN:       state_d = ST_FIN;
      ST_FIN:       if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // unit control and operand selection
  always_comb begin
    div_start    = 1'b0;
    sqrt_start   = 1'b0;
    div_dividend = sum_q;
    div_divisor  = DvsW'(cnt_q);
    unique case (state_q)
      ST_MEAN_GO: div_start = 1'b1;
      ST_SQRT_GO: sqrt_start = 1'b1;
      ST_PCT_GO: begin
        div_start    = 1'b1;
        div_dividend = DivW'(prod_q);
        div_divisor  = peak_q;
      end
      default: begin
        div_start  = 1'b0;
        sqrt_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sum_q     <= '0;
      cnt_q     <= '0;
      peak_q    <= '0;
      tog_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_FIN) && out_free) out_vld_q <= 1'b1;
      else if (out_ch.ready) out_vld_q <= 1'b0;
      case (state_q)
        ST_ADD: begin
          if (cnt_q < CntW'(MaxFrame)) begin
            sum_q <= sum_q + SumW'(sq_q);
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_CMP: begin
          if (rms_q > peak_q) begin
            peak_q <= rms_q;
            tog_q  <= ~tog_q;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            peak_q    <= peak_decayed;
            sum_q     <= '0;
            cnt_q     <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_max_q <= LedMaxRst;
      decay_q   <= DecayRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LED_MAX: led_max_q <= cfg_data_i[LedW-1:0];
        CFG_DECAY:   decay_q   <= cfg_data_i[DecW-1:0];
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        mag_q  <= mag;
        last_q <= in_ch.last_of_frame;
      end
      ST_SQUARE: sq_q <= mag_q * mag_q;
      ST_SQRT_WAIT: rms_q <= sqrt_root;
      ST_CMP: begin
        prod_q  <= rms_q * Hundred;
        red_q   <= '0;
        green_q <= '0;
        blue_q  <= '0;
        if (rms_q > peak_q) begin
          if (tog_q) red_q <= led_max_q;
          else blue_q <= led_max_q;
        end
      end
      ST_PCT_WAIT: gprod_q <= div_quot[PctW-1:0] * led_max_q;
      ST_GRN: green_q <= grn_prod[RecipSh +: LedW];
      ST_FIN: begin
        if (out_free) begin
          out_red_q   <= red_q;
          out_green_q <= green_q;
          out_blue_q  <= blue_q;
          out_rms_q   <= rms_q;
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready        = (state_q == ST_IDLE);
  assign out_ch.valid       = out_vld_q;
  assign out_ch.red_level   = out_red_q;
  assign out_ch.green_level = out_green_q;
  assign out_ch.blue_level  = out_blue_q;
  assign out_ch.rms_value   = out_rms_q;

endmodule

>>> hdl/rpl_checker.sv
// port-level checks on the meter core and their bind
module rpl_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [rpl_pkg::LedW-1:0] red_i,
  input logic [rpl_pkg::LedW-1:0] blue_i,
  input logic [rpl_pkg::RmsW-1:0] rms_i
);
  import rpl_pkg::*;

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // input ready is low in the cycle after each accepted sample word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("sample word accepted on back-to-back cycles");

  // a peak event lights only one of red and blue
  a_one_peak_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (red_i == '0) || (blue_i == '0))
    else $error("red and blue lit together");

  // unsigned q1.15 rms never goes above one
  a_rms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (rms_i <= RmsW'(32768)))
    else $error("rms out of range");

endmodule

bind rms_peak_led_meter_core rpl_checker u_rpl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .red_i       (out_ch.red_level),
  .blue_i      (out_ch.blue_level),
  .rms_i       (out_ch.rms_value)
);
